### rtl/mmdpq_pkg.sv
`timescale 1ns / 1ps

package mmdpq_pkg;

    localparam int CAPACITY     = 1023;
    localparam int PAYLOAD_BITS = 32;

    localparam int KEY_W       = 32;
    localparam int PORT_PAY_W  = 32;
    localparam int COUNT_OUT_W = 10;
    localparam int STATUS_W    = 2;

    // heap levels; node ids are 1-based, level of id n is the msb of n
    localparam int LEVELS = $clog2(CAPACITY + 1);
    localparam int ID_W   = LEVELS;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [ID_W-1:0] t_id;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic [PAYLOAD_BITS-1:0] pay;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // read request qualifiers, latched by the cell that serves the read
    typedef struct packed {
        logic down;
        logic lane;
        logic right_ok;
    } t_rdctl;

    // compare result travelling along the chain of level cells
    typedef struct packed {
        logic   hit;
        logic   lane;
        logic   beats;
        t_entry ent;
    } t_pick;

    function automatic logic f_better(input logic mode, input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b);
        return mode ? (a > b) : (a < b);
    endfunction

endpackage

### rtl/mmdpq_ram.sv
`timescale 1ns / 1ps

module mmdpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mmdpq_cell.sv
`timescale 1ns / 1ps

module mmdpq_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_sel,
    input  mmdpq_pkg::t_rdctl              i_ctl,
    input  logic                           i_mode,
    input  logic [mmdpq_pkg::KEY_W-1:0]    i_move_key,
    input  mmdpq_pkg::t_entry              i_lane0,
    input  mmdpq_pkg::t_entry              i_lane1,
    input  mmdpq_pkg::t_pick               i_chain,
    output mmdpq_pkg::t_pick               o_chain
);

    import mmdpq_pkg::*;

    logic   r_hit;
    t_rdctl r_ctl;
    logic   take_right;
    t_entry sel;
    t_pick  mine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= i_rd_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_sel) begin
            r_ctl <= i_ctl;
        end
    end

    always_comb begin
        // sift down: better child, left on a tie; sift up: the parent's lane
        if (r_ctl.down) begin
            take_right = r_ctl.right_ok && f_better(i_mode, i_lane1.key, i_lane0.key);
        end else begin
            take_right = r_ctl.lane;
        end
        sel        = take_right ? i_lane1 : i_lane0;
        mine.hit   = 1'b1;
        mine.lane  = take_right;
        mine.beats = r_ctl.down ? f_better(i_mode, sel.key, i_move_key)
                                : f_better(i_mode, i_move_key, sel.key);
        mine.ent   = sel;
        o_chain    = r_hit ? mine : i_chain;
    end

endmodule

### rtl/min_max_distance_priority_queue.sv
`timescale 1ns / 1ps
// Insert: after accept, the sift up compares against each parent in turn until it stops, then
// goes to the result state. Pop: fetch of the last entry, then the sift down walks level by level.
// Pop on empty and insert on full go straight to the result state. One item at a time, the next
// is taken on return to idle, after the result state has loaded the output.
// Reset: synchronous active low, clears count, mode and handshake; stores are not cleared.

module min_max_distance_priority_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_opcode,
    input  logic [mmdpq_pkg::KEY_W-1:0]          i_new_key,
    input  logic [mmdpq_pkg::PORT_PAY_W-1:0]     i_new_payload,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [mmdpq_pkg::STATUS_W-1:0]       o_status,
    output logic [mmdpq_pkg::KEY_W-1:0]          o_popped_key,
    output logic [mmdpq_pkg::PORT_PAY_W-1:0]     o_popped_payload,
    output logic [mmdpq_pkg::COUNT_OUT_W-1:0]    o_entry_count,
    output logic [mmdpq_pkg::KEY_W-1:0]          o_root_key
);

    import mmdpq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_DOWN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0]              r_state, n_state;
    t_id                     r_cnt, n_cnt;
    logic                    r_mode, n_mode;
    t_id                     r_id, n_id;
    t_entry                  r_move, n_move;
    logic [STATUS_W-1:0]     r_status, n_status;
    t_entry                  r_popped, n_popped;
    t_entry                  r_root;
    logic                    r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]     r_out_status, n_out_status;
    t_entry                  r_out_popped, n_out_popped;
    logic [COUNT_OUT_W-1:0]  r_out_count, n_out_count;
    logic [KEY_W-1:0]        r_out_root, n_out_root;

    logic                    rd_en;
    t_id                     rd_id;
    t_rdctl                  rd_ctl;
    logic                    wr_en;
    t_id                     wr_id;
    t_entry                  wr_ent;
    t_entry                  new_ent;
    t_id                     ins_id;
    t_id                     par_id;
    t_id                     child_id;
    logic [ID_W:0]           gc_left;
    logic [ID_W:0]           gc_right;
    logic [ID_W:0]           cnt_ext;
    logic                    accept;

    logic [LEVELS-1:0]       rd_sel;
    logic [LEVELS-1:0]       wr_sel;
    t_pick                   w_chain [0:LEVELS];
    t_pick                   pick;

    assign w_chain[LEVELS] = '0;
    assign pick            = w_chain[0];

    for (genvar g_lvl = 0; g_lvl < LEVELS; g_lvl++) begin : g_level
        t_entry lane0;
        t_entry lane1;

        assign rd_sel[g_lvl] = rd_en && ((rd_id >> g_lvl) == t_id'(1));
        assign wr_sel[g_lvl] = wr_en && ((wr_id >> g_lvl) == t_id'(1));

        if (g_lvl == 0) begin : g_root
            assign lane0 = r_root;
            assign lane1 = r_root;
        end else begin : g_mem
            localparam int ROWS = 1 << (g_lvl - 1);
            localparam int AW   = (ROWS > 1) ? (g_lvl - 1) : 1;
            logic [AW-1:0] rd_row;
            logic [AW-1:0] wr_row;

            if (g_lvl >= 2) begin : g_row
                assign rd_row = rd_id[g_lvl-1:1];
                assign wr_row = wr_id[g_lvl-1:1];
            end else begin : g_row0
                assign rd_row = '0;
                assign wr_row = '0;
            end

            mmdpq_ram #(
                .WIDTH (ENTRY_W),
                .DEPTH (ROWS)
            ) u_lane0 (
                .i_clk   (i_clk),
                .i_we    (wr_sel[g_lvl] && !wr_id[0]),
                .i_waddr (wr_row),
                .i_wdata (wr_ent),
                .i_re    (rd_sel[g_lvl]),
                .i_raddr (rd_row),
                .o_rdata (lane0)
            );

            mmdpq_ram #(
                .WIDTH (ENTRY_W),
                .DEPTH (ROWS)
            ) u_lane1 (
                .i_clk   (i_clk),
                .i_we    (wr_sel[g_lvl] && wr_id[0]),
                .i_waddr (wr_row),
                .i_wdata (wr_ent),
                .i_re    (rd_sel[g_lvl]),
                .i_raddr (rd_row),
                .o_rdata (lane1)
            );
        end

        mmdpq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_rd_sel   (rd_sel[g_lvl]),
            .i_ctl      (rd_ctl),
            .i_mode     (r_mode),
            .i_move_key (r_move.key),
            .i_lane0    (lane0),
            .i_lane1    (lane1),
            .i_chain    (w_chain[g_lvl+1]),
            .o_chain    (w_chain[g_lvl])
        );
    end

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_mode       = i_cfg_we ? i_cfg_wdata : r_mode;
        n_id         = r_id;
        n_move       = r_move;
        n_status     = r_status;
        n_popped     = r_popped;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_popped = r_out_popped;
        n_out_count  = r_out_count;
        n_out_root   = r_out_root;
        rd_en        = 1'b0;
        rd_id        = '0;
        rd_ctl       = '0;
        wr_en        = 1'b0;
        wr_id        = '0;
        wr_ent       = r_move;

        new_ent.key  = i_new_key;
        new_ent.pay  = PAYLOAD_BITS'(i_new_payload);
        ins_id       = r_cnt + t_id'(1);
        par_id       = r_id >> 1;
        child_id     = t_id'({r_id, pick.lane});
        cnt_ext      = {1'b0, r_cnt};
        gc_left      = {child_id, 1'b0};
        gc_right     = {child_id, 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_move   = new_ent;
                    n_status = ST_DONE;
                    n_popped = '0;
                    if (i_opcode == OP_INSERT) begin
                        if (r_cnt == t_id'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_RES;
                        end else begin
                            n_cnt = ins_id;
                            if (r_cnt == '0) begin
                                wr_en   = 1'b1;
                                wr_id   = t_id'(1);
                                wr_ent  = new_ent;
                                n_state = S_RES;
                            end else begin
                                rd_en       = 1'b1;
                                rd_id       = ins_id >> 1;
                                rd_ctl.lane = ins_id[1];
                                n_id        = ins_id;
                                n_state     = S_UP;
                            end
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RES;
                        end else begin
                            n_popped = r_root;
                            n_cnt    = r_cnt - t_id'(1);
                            if (r_cnt == t_id'(1)) begin
                                n_state = S_RES;
                            end else begin
                                // fetch the last entry
                                rd_en       = 1'b1;
                                rd_id       = r_cnt;
                                rd_ctl.lane = r_cnt[0];
                                n_id        = t_id'(1);
                                n_state     = S_LAST;
                            end
                        end
                    end
                end
            end
            S_UP: begin
                wr_en = 1'b1;
                wr_id = r_id;
                if (pick.beats) begin
                    wr_ent = pick.ent;
                    n_id   = par_id;
                    if (par_id != t_id'(1)) begin
                        rd_en       = 1'b1;
                        rd_id       = par_id >> 1;
                        rd_ctl.lane = par_id[1];
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_RES;
                end
            end
            S_LAST: begin
                n_move = pick.ent;
                if (r_cnt >= t_id'(2)) begin
                    rd_en           = 1'b1;
                    rd_id           = t_id'(2);
                    rd_ctl.down     = 1'b1;
                    rd_ctl.right_ok = (r_cnt >= t_id'(3));
                    n_state         = S_DOWN;
                end else begin
                    wr_en   = 1'b1;
                    wr_id   = t_id'(1);
                    wr_ent  = pick.ent;
                    n_state = S_RES;
                end
            end
            S_DOWN: begin
                wr_en = 1'b1;
                wr_id = r_id;
                if (pick.beats) begin
                    wr_ent = pick.ent;
                    n_id   = child_id;
                    if (gc_left <= cnt_ext) begin
                        rd_en           = 1'b1;
                        rd_id           = gc_left[ID_W-1:0];
                        rd_ctl.down     = 1'b1;
                        rd_ctl.right_ok = (gc_right <= cnt_ext);
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_RES;
                end
            end
            S_FIN: begin
                wr_en   = 1'b1;
                wr_id   = r_id;
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_popped = r_popped;
                    n_out_count  = COUNT_OUT_W'(r_cnt);
                    n_out_root   = (r_cnt != '0) ? r_root.key : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id         <= n_id;
        r_move       <= n_move;
        r_status     <= n_status;
        r_popped     <= n_popped;
        r_out_status <= n_out_status;
        r_out_popped <= n_out_popped;
        r_out_count  <= n_out_count;
        r_out_root   <= n_out_root;
        if (wr_sel[0]) begin
            r_root <= wr_ent;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_popped_key     = r_out_popped.key;
    assign o_popped_payload = PORT_PAY_W'(r_out_popped.pay);
    assign o_entry_count    = r_out_count;
    assign o_root_key       = r_out_root;

    a_one_level_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(rd_sel))
        else $error("reads issued to more than one level");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_id'(CAPACITY))
        else $error("entry count beyond capacity");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_POP && r_cnt != '0) |=> (r_cnt == $past(r_cnt) - t_id'(1)))
        else $error("pop did not drop the count by one");

    a_result_from_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RES))
        else $error("result loaded outside the result state");

endmodule

### bench/tb_min_max_distance_priority_queue.sv
`timescale 1ns / 1ps

module tb_min_max_distance_priority_queue;
    import mmdpq_pkg::*;

    localparam int IDLE_PCT    = 22;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic                  op;
        logic [KEY_W-1:0]      key;
        logic [PORT_PAY_W-1:0] pay;
    } t_heap_op;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [KEY_W-1:0]       popped_key;
        logic [PORT_PAY_W-1:0]  popped_payload;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [KEY_W-1:0]       root_key;
    } t_heap_result;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_wdata   = 1'b0;
    logic                   i_valid       = 1'b0;
    logic                   i_opcode      = OP_INSERT;
    logic [KEY_W-1:0]       i_new_key     = '0;
    logic [PORT_PAY_W-1:0]  i_new_payload = '0;
    logic                   i_stall       = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [KEY_W-1:0]       o_popped_key;
    logic [PORT_PAY_W-1:0]  o_popped_payload;
    logic [COUNT_OUT_W-1:0] o_entry_count;
    logic [KEY_W-1:0]       o_root_key;

    // heap mirror
    logic [KEY_W-1:0]        key_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];
    int unsigned             held = 0;
    bit                      max_first = 1'b0;

    t_heap_op     pending_ops [$];
    t_heap_result expected_results [$];
    t_heap_op     next_op;
    bit           item_taken = 1'b0;
    bit           quiet = 1'b0;
    int unsigned  ops_queued = 0;
    int unsigned  results_seen = 0;
    int unsigned  mismatches = 0;
    int unsigned  cycles = 0;

    min_max_distance_priority_queue DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_new_key        (i_new_key),
        .i_new_payload    (i_new_payload),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_popped_key     (o_popped_key),
        .o_popped_payload (o_popped_payload),
        .o_entry_count    (o_entry_count),
        .o_root_key       (o_root_key)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit key_beats(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        return max_first ? (a > b) : (a < b);
    endfunction

    function automatic t_heap_result heap_apply(t_heap_op op);
        t_heap_result            res;
        int unsigned             idx;
        int unsigned             par;
        int unsigned             kid;
        logic [KEY_W-1:0]        mv_key;
        logic [PAYLOAD_BITS-1:0] mv_pay;
        res = '{ST_DONE, '0, '0, '0, '0};
        if (op.op == OP_INSERT) begin
            if (held >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                idx = held;
                while (idx > 0) begin
                    par = (idx - 1) / 2;
                    if (!key_beats(op.key, key_mem[par]))
                        break;
                    key_mem[idx] = key_mem[par];
                    pay_mem[idx] = pay_mem[par];
                    idx = par;
                end
                key_mem[idx] = op.key;
                pay_mem[idx] = op.pay;
                held++;
            end
        end else if (held == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.popped_key     = key_mem[0];
            res.popped_payload = pay_mem[0];
            held--;
            mv_key = key_mem[held];
            mv_pay = pay_mem[held];
            if (held != 0) begin
                idx = 0;
                while (2 * idx + 1 < held) begin
                    kid = 2 * idx + 1;
                    if (kid + 1 < held && key_beats(key_mem[kid + 1], key_mem[kid]))
                        kid++;
                    if (!key_beats(key_mem[kid], mv_key))
                        break;
                    key_mem[idx] = key_mem[kid];
                    pay_mem[idx] = pay_mem[kid];
                    idx = kid;
                end
                key_mem[idx] = mv_key;
                pay_mem[idx] = mv_pay;
            end
        end
        res.entry_count = held[COUNT_OUT_W-1:0];
        res.root_key    = (held != 0) ? key_mem[0] : '0;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        if (!i_valid || item_taken) begin
            item_taken = 1'b0;
            if (i_rst_n && pending_ops.size() != 0
                    && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                next_op = pending_ops.pop_front();
                i_valid       <= 1'b1;
                i_opcode      <= next_op.op;
                i_new_key     <= next_op.key;
                i_new_payload <= next_op.pay;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n) begin
            if (i_cfg_we)
                max_first = i_cfg_wdata;
            if (i_valid && !o_stall) begin
                expected_results.push_back(heap_apply('{i_opcode, i_new_key, i_new_payload}));
                item_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no item waiting, status %h key %h",
                             $time, o_status, o_popped_key);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("popped_key", want.popped_key, o_popped_key);
                    check_field("popped_payload", want.popped_payload, o_popped_payload);
                    check_field("entry_count", want.entry_count, o_entry_count);
                    check_field("root_key", want.root_key, o_root_key);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_op(logic op, logic [KEY_W-1:0] key, logic [PORT_PAY_W-1:0] pay);
        pending_ops.push_back('{op, key, pay});
        ops_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (results_seen != ops_queued);
    endtask

    task automatic write_mode(bit mode);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 15);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h0001_0000;
                    default: return 32'h8000_0000;
                endcase
            end
            2: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(int count, int pop_pct);
        for (int n = 0; n < count; n++)
            queue_op(($urandom_range(99) < pop_pct) ? OP_POP : OP_INSERT, rand_key(), $urandom);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(1'b0);

        // least-first: empty pop, extremes, ties between equal keys
        queue_op(OP_POP,    32'h0000_0000, 32'h0000_0000);
        queue_op(OP_INSERT, 32'h0001_8000, 32'h0000_0000);
        queue_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
        queue_op(OP_INSERT, 32'h0000_0000, 32'hAAAA_AAAA);
        queue_op(OP_INSERT, 32'h8000_0000, 32'h5555_5555);
        queue_op(OP_INSERT, 32'h0001_8000, 32'h0F0F_0F0F);
        queue_op(OP_POP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_POP,    32'h0000_0000, 32'h0000_0000);
        queue_op(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(OP_POP,    32'h0000_0000, 32'h0000_0000);

        // flip to greatest-first with entries still held
        write_mode(1'b1);
        queue_op(OP_POP,    32'h0000_0000, 32'h0000_0000);
        queue_op(OP_POP,    32'h0000_0000, 32'h0000_0000);
        queue_op(OP_POP,    32'h0000_0000, 32'h0000_0000);
        queue_op(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        repeat (5) queue_op(OP_POP, 32'h0000_0000, 32'h0000_0000);

        queue_random(300, 40);

        write_mode(1'b0);
        quiet = 1'b1;
        queue_random(250, 35);
        wait_drained();
        quiet = 1'b0;

        // fill to capacity, then a few inserts on a full heap
        for (int n = held; n < CAPACITY + 3; n++)
            queue_op(OP_INSERT, rand_key(), $urandom);

        write_mode(1'b1);
        queue_random(400, 70);

        wait_drained();
        repeat (LEVELS + 4) @(posedge i_clk);
        if (expected_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
